### hw/rtl/ito_pkg.sv
// shared types, character constants and the control program of the integer formatter
`timescale 1ns / 1ps

package ito_pkg;

    localparam logic [5:0]  MAX_WIDTH = 6'd48;
    localparam int          DIG_DEPTH = 10;
    localparam int          DIG_IW    = $clog2(DIG_DEPTH);
    localparam int          PC_W      = 4;
    localparam logic [31:0] RECIP10   = 32'hCCCC_CCCD;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h61;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_X     = 7'h78;
    localparam logic [6:0] CH_SPACE = 7'h20;

    localparam logic [1:0] KIND_DEC  = 2'd0;
    localparam logic [1:0] KIND_HEXP = 2'd2;
    localparam logic [1:0] SIGN_PLUS = 2'd1;
    localparam logic [1:0] SIGN_MIN  = 2'd2;
    localparam logic [1:0] PAD_SPACE = 2'd1;
    localparam logic [1:0] PAD_ZERO  = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] value;
        logic [1:0]         sign_mode;
        logic [1:0]         pad_mode;
        logic [5:0]         width;
    } t_in_word;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last;
    } t_out_word;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_DIV,
        OP_REM,
        OP_PADSET,
        OP_EMIT,
        OP_JUMP
    } t_op;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_X,
        SRC_PLUS,
        SRC_MINUS,
        SRC_PAD,
        SRC_DIGIT
    } t_src;

    typedef enum logic [2:0] {
        G_ALWAYS,
        G_PFX,
        G_PLUS,
        G_NEG,
        G_PAD
    } t_gate;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOACC,
        C_QNZ,
        C_PADMORE,
        C_DIGMORE
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_src            src;
        t_gate           gate;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_op  op;
        t_src src;
        logic go;
    } t_ctrl;

    // datapath to sequencer
    typedef struct packed {
        logic accept;
        logic q_nz;
        logic pad_nz;
        logic pad_more;
        logic dig_more;
        logic slot_free;
        logic pfx;
        logic plus;
        logic neg;
    } t_stat;

    function automatic t_uword ito_rom(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            4'd0:    w = '{op: OP_LOAD,   src: SRC_ZERO,  gate: G_ALWAYS, cond: C_NOACC,
                           target: 4'd0};
            4'd1:    w = '{op: OP_DIV,    src: SRC_ZERO,  gate: G_ALWAYS, cond: C_NEVER,
                           target: 4'd0};
            4'd2:    w = '{op: OP_REM,    src: SRC_ZERO,  gate: G_ALWAYS, cond: C_QNZ,
                           target: 4'd1};
            4'd3:    w = '{op: OP_PADSET, src: SRC_ZERO,  gate: G_ALWAYS, cond: C_NEVER,
                           target: 4'd0};
            4'd4:    w = '{op: OP_EMIT,   src: SRC_ZERO,  gate: G_PFX,    cond: C_NEVER,
                           target: 4'd0};
            4'd5:    w = '{op: OP_EMIT,   src: SRC_X,     gate: G_PFX,    cond: C_NEVER,
                           target: 4'd0};
            4'd6:    w = '{op: OP_EMIT,   src: SRC_PLUS,  gate: G_PLUS,   cond: C_NEVER,
                           target: 4'd0};
            4'd7:    w = '{op: OP_EMIT,   src: SRC_MINUS, gate: G_NEG,    cond: C_NEVER,
                           target: 4'd0};
            4'd8:    w = '{op: OP_EMIT,   src: SRC_PAD,   gate: G_PAD,    cond: C_PADMORE,
                           target: 4'd8};
            4'd9:    w = '{op: OP_EMIT,   src: SRC_DIGIT, gate: G_ALWAYS, cond: C_DIGMORE,
                           target: 4'd9};
            default: w = '{op: OP_JUMP,   src: SRC_ZERO,  gate: G_ALWAYS, cond: C_ALWAYS,
                           target: 4'd0};
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/ito_seq.sv
// step counter, control store and branch logic of the integer formatter
`timescale 1ns / 1ps

module ito_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ito_pkg::t_stat i_stat,
    output ito_pkg::t_ctrl o_ctrl
);

    logic [ito_pkg::PC_W-1:0] r_pc;
    logic [ito_pkg::PC_W-1:0] n_pc;
    ito_pkg::t_uword          w;
    logic                     gate_ok;
    logic                     cond_ok;

    always_comb begin
        w = ito_pkg::ito_rom(r_pc);
    end

    always_comb begin
        case (w.gate)
            ito_pkg::G_ALWAYS: gate_ok = 1'b1;
            ito_pkg::G_PFX:    gate_ok = i_stat.pfx;
            ito_pkg::G_PLUS:   gate_ok = i_stat.plus;
            ito_pkg::G_NEG:    gate_ok = i_stat.neg;
            ito_pkg::G_PAD:    gate_ok = i_stat.pad_nz;
            default:           gate_ok = 1'b0;
        endcase
    end

    always_comb begin
        case (w.cond)
            ito_pkg::C_NEVER:   cond_ok = 1'b0;
            ito_pkg::C_ALWAYS:  cond_ok = 1'b1;
            ito_pkg::C_NOACC:   cond_ok = !i_stat.accept;
            ito_pkg::C_QNZ:     cond_ok = i_stat.q_nz;
            ito_pkg::C_PADMORE: cond_ok = i_stat.pad_more;
            ito_pkg::C_DIGMORE: cond_ok = i_stat.dig_more;
            default:            cond_ok = 1'b0;
        endcase
    end

    // control to the datapath
    always_comb begin
        o_ctrl.op  = w.op;
        o_ctrl.src = w.src;
        case (w.op)
            ito_pkg::OP_LOAD: o_ctrl.go = i_stat.accept;
            ito_pkg::OP_EMIT: o_ctrl.go = gate_ok && i_stat.slot_free;
            ito_pkg::OP_JUMP: o_ctrl.go = 1'b0;
            default:          o_ctrl.go = 1'b1;
        endcase
    end

    // next step
    always_comb begin
        n_pc = r_pc + 4'd1;
        if (w.op == ito_pkg::OP_EMIT && !gate_ok) begin
            n_pc = r_pc + 4'd1;
        end else if (w.op == ito_pkg::OP_EMIT && !i_stat.slot_free) begin
            n_pc = r_pc;
        end else if (cond_ok) begin
            n_pc = w.target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

### hw/rtl/ito_dp.sv
// operand registers, digit extraction, digit buffer and output register
`timescale 1ns / 1ps

module ito_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ito_pkg::t_ctrl    i_ctrl,
    input  logic              i_in_valid,
    input  ito_pkg::t_in_word i_in_word,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output ito_pkg::t_out_word o_out_word,
    output ito_pkg::t_stat    o_stat
);

    localparam int DIG_W = ito_pkg::DIG_IW;

    logic [1:0]  r_kind;
    logic [1:0]  r_smode;
    logic [1:0]  r_pmode;
    logic [5:0]  r_fw;
    logic        r_neg;
    logic [31:0] r_mag;
    logic [63:0] r_prod;
    logic [DIG_W-1:0] r_nd;
    logic [5:0]  r_pad;
    logic [6:0]  r_dig [ito_pkg::DIG_DEPTH];
    logic        r_out_valid;
    ito_pkg::t_out_word r_out_word;

    logic        accept;
    logic        dec;
    logic [31:0] q;
    logic [31:0] q_x10;
    logic [3:0]  rem;
    logic [6:0]  rem_char;
    logic        sflag;
    logic [7:0]  need;
    logic [7:0]  fw8;
    logic [7:0]  pad8;
    logic        pad_en;
    logic [DIG_W-1:0] rd_idx;
    logic [6:0]  emit_char;
    logic        emit_last;
    logic        in_neg;
    logic [31:0] in_raw;

    assign o_in_ready = (i_ctrl.op == ito_pkg::OP_LOAD);
    assign accept     = i_in_valid && o_in_ready;
    assign dec        = (r_kind == ito_pkg::KIND_DEC);
    assign in_raw     = i_in_word.value;
    assign in_neg     = in_raw[31];

    // quotient and remainder of one digit step
    always_comb begin
        if (dec) begin
            q = {3'b0, r_prod[63:35]};
        end else begin
            q = {4'b0, r_mag[31:4]};
        end
        q_x10 = dec ? ((q << 3) + (q << 1)) : (q << 4);
        rem   = 4'(r_mag - q_x10);
        if (rem > 4'd9) begin
            rem_char = ito_pkg::CH_A + {3'b0, rem} - 7'd10;
        end else begin
            rem_char = ito_pkg::CH_ZERO + {3'b0, rem};
        end
    end

    // pad count
    always_comb begin
        sflag  = (r_smode == ito_pkg::SIGN_PLUS) || (r_smode == ito_pkg::SIGN_MIN);
        need   = {{(8-DIG_W){1'b0}}, r_nd} + {7'b0, sflag};
        fw8    = {2'b0, r_fw};
        pad8   = fw8 - need;
        pad_en = (r_pmode == ito_pkg::PAD_SPACE) || (r_pmode == ito_pkg::PAD_ZERO);
    end

    assign rd_idx = r_nd - 1'b1;

    always_comb begin
        emit_last = 1'b0;
        case (i_ctrl.src)
            ito_pkg::SRC_ZERO:  emit_char = ito_pkg::CH_ZERO;
            ito_pkg::SRC_X:     emit_char = ito_pkg::CH_X;
            ito_pkg::SRC_PLUS:  emit_char = ito_pkg::CH_PLUS;
            ito_pkg::SRC_MINUS: emit_char = ito_pkg::CH_MINUS;
            ito_pkg::SRC_PAD: begin
                emit_char = (r_pmode == ito_pkg::PAD_ZERO) ? ito_pkg::CH_ZERO
                                                           : ito_pkg::CH_SPACE;
            end
            ito_pkg::SRC_DIGIT: begin
                emit_char = r_dig[rd_idx];
                emit_last = (r_nd == DIG_W'(1));
            end
            default:            emit_char = ito_pkg::CH_ZERO;
        endcase
    end

    always_comb begin
        o_stat.accept    = accept;
        o_stat.q_nz      = (q != 32'd0);
        o_stat.pad_nz    = (r_pad != 6'd0);
        o_stat.pad_more  = (r_pad != 6'd1);
        o_stat.dig_more  = (r_nd != DIG_W'(1));
        o_stat.slot_free = !r_out_valid || i_out_ready;
        o_stat.pfx       = (r_kind == ito_pkg::KIND_HEXP);
        o_stat.plus      = (r_smode == ito_pkg::SIGN_PLUS) && !r_neg;
        o_stat.neg       = r_neg;
    end

    // operand and work registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd  <= '0;
            r_pad <= '0;
        end else if (i_ctrl.go) begin
            case (i_ctrl.op)
                ito_pkg::OP_LOAD: begin
                    r_kind  <= i_in_word.req_type;
                    r_smode <= i_in_word.sign_mode;
                    r_pmode <= i_in_word.pad_mode;
                    r_fw    <= (i_in_word.width > ito_pkg::MAX_WIDTH) ? ito_pkg::MAX_WIDTH
                                                                      : i_in_word.width;
                    r_neg   <= in_neg;
                    r_mag   <= in_neg ? (32'd0 - in_raw) : in_raw;
                    r_nd    <= '0;
                    r_pad   <= '0;
                end
                ito_pkg::OP_DIV: begin
                    r_prod <= r_mag * ito_pkg::RECIP10;
                end
                ito_pkg::OP_REM: begin
                    r_dig[r_nd] <= rem_char;
                    r_nd        <= r_nd + 1'b1;
                    r_mag       <= q;
                end
                ito_pkg::OP_PADSET: begin
                    if (pad_en && (fw8 > need)) begin
                        r_pad <= pad8[5:0];
                    end else begin
                        r_pad <= '0;
                    end
                end
                ito_pkg::OP_EMIT: begin
                    if (i_ctrl.src == ito_pkg::SRC_PAD) begin
                        r_pad <= r_pad - 6'd1;
                    end
                    if (i_ctrl.src == ito_pkg::SRC_DIGIT) begin
                        r_nd <= rd_idx;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.go && i_ctrl.op == ito_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.go && i_ctrl.op == ito_pkg::OP_EMIT) begin
            r_out_word.out_char <= emit_char;
            r_out_word.last     <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### hw/rtl/integer_to_ascii_formatter.sv
// top level of the integer formatter: control sequencer plus datapath
// an accepted number runs load, digit extraction, pad count, then prefix, sign, pad and digit emits;
// nd, the digit count, is 1 to 10; each digit takes a reciprocal multiply, then a remainder step
// each character leaves through the output register, and a full one stalls the emit step;
// a new number is accepted only after the last digit of the previous one is emitted
// synchronous active-low reset returns the step counter to the wait step, output empty
`timescale 1ns / 1ps

module integer_to_ascii_formatter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ito_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ito_pkg::t_out_word o_out_word
);

    ito_pkg::t_ctrl ctrl;
    ito_pkg::t_stat stat;

    ito_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    ito_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_stat      (stat)
    );

endmodule

### dv/tb.sv
// self-checking testbench for the integer to ascii formatter
`timescale 1ns / 1ps

module tb;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    ito_pkg::t_in_word  i_in_word;
    logic               o_out_valid;
    logic               i_out_ready;
    ito_pkg::t_out_word o_out_word;

    ito_pkg::t_out_word exp_chars[$];
    int        errors;
    bit        tx_idle;
    bit        rx_idle;
    bit        hold_req;

    localparam logic [1:0] KIND_HEX   = 2'd1;
    localparam logic [1:0] KIND_ODD   = 2'd3;
    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_ODD   = 2'd3;
    localparam logic [1:0] PAD_NONE   = 2'd0;
    localparam logic [1:0] PAD_ODD    = 2'd3;
    localparam int         HOLD_CYCLES = 400;

    integer_to_ascii_formatter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic ito_pkg::t_in_word mk_word(logic [1:0] kind, logic [31:0] val,
                                                  logic [1:0] smode, logic [1:0] pmode,
                                                  logic [5:0] fw);
        ito_pkg::t_in_word w;
        w.req_type  = kind;
        w.value     = val;
        w.sign_mode = smode;
        w.pad_mode  = pmode;
        w.width     = fw;
        return w;
    endfunction

    // expected character stream of one number: prefix, sign, pad, then digits
    function automatic void predict_chars(ito_pkg::t_in_word w);
        logic        neg;
        logic [31:0] base;
        logic [31:0] mag;
        logic [31:0] m;
        logic [31:0] r;
        logic [6:0]  digs [16];
        logic [6:0]  chars [$];
        int          fw;
        int          nd;
        int          pad;
        int          i;
        ito_pkg::t_out_word o;
        neg  = w.value[31];
        base = (w.req_type == ito_pkg::KIND_DEC) ? 32'd10 : 32'd16;
        mag  = neg ? (32'd0 - w.value) : w.value;
        fw   = (w.width > ito_pkg::MAX_WIDTH) ? int'(ito_pkg::MAX_WIDTH) : int'(w.width);
        if (w.req_type == ito_pkg::KIND_HEXP) begin
            chars.push_back(ito_pkg::CH_ZERO);
            chars.push_back(ito_pkg::CH_X);
        end
        if (w.sign_mode == ito_pkg::SIGN_PLUS && !neg)
            chars.push_back(ito_pkg::CH_PLUS);
        if (neg)
            chars.push_back(ito_pkg::CH_MINUS);
        nd = 1;
        m  = mag;
        while (m >= base) begin
            m  = m / base;
            nd = nd + 1;
        end
        if (w.pad_mode == ito_pkg::PAD_SPACE || w.pad_mode == ito_pkg::PAD_ZERO) begin
            pad = fw - nd;
            if (w.sign_mode == ito_pkg::SIGN_PLUS || w.sign_mode == ito_pkg::SIGN_MIN)
                pad = pad - 1;
            for (i = 0; i < pad; i++)
                chars.push_back((w.pad_mode == ito_pkg::PAD_ZERO) ? ito_pkg::CH_ZERO
                                                                  : ito_pkg::CH_SPACE);
        end
        m = mag;
        for (i = 0; i < nd; i++) begin
            r       = m % base;
            m       = m / base;
            digs[i] = (r > 32'd9) ? 7'(ito_pkg::CH_A + r - 32'd10)
                                  : 7'(ito_pkg::CH_ZERO + r);
        end
        for (i = nd - 1; i >= 0; i--)
            chars.push_back(digs[i]);
        for (i = 0; i < chars.size(); i++) begin
            o.out_char = chars[i];
            o.last     = (i == chars.size() - 1);
            exp_chars.push_back(o);
        end
    endfunction

    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 20);
            2: v = 32'd0 - $urandom_range(1, 20);
            3: v = 32'h8000_0000 ^ $urandom_range(0, 3);
            4: v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    function automatic ito_pkg::t_in_word rand_word();
        logic [1:0] pmode;
        if ($urandom_range(0, 9) < 7)
            pmode = $urandom_range(0, 1) ? ito_pkg::PAD_SPACE : ito_pkg::PAD_ZERO;
        else
            pmode = $urandom_range(0, 1) ? PAD_NONE : PAD_ODD;
        return mk_word(2'($urandom_range(0, 3)), rand_value(), 2'($urandom_range(0, 3)),
                       pmode, 6'($urandom_range(0, 63)));
    endfunction

    // valid stays up across back-to-back words, dropped only for a gap
    task automatic send_word(ito_pkg::t_in_word w);
        int gap;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        predict_chars(w);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            i_in_word  <= ito_pkg::t_in_word'({$urandom, $urandom});
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic test_kinds_and_extremes();
        send_word(mk_word(ito_pkg::KIND_DEC,  32'd0,         SIGN_NONE, PAD_NONE, 6'd0));
        send_word(mk_word(ito_pkg::KIND_DEC,  32'h7fff_ffff, SIGN_NONE, PAD_NONE, 6'd0));
        send_word(mk_word(ito_pkg::KIND_DEC,  32'h8000_0000, SIGN_NONE, PAD_NONE, 6'd0));
        send_word(mk_word(ito_pkg::KIND_DEC,  32'hffff_ffff, SIGN_NONE, PAD_NONE, 6'd0));
        send_word(mk_word(KIND_HEX,           32'h7fff_ffff, SIGN_NONE, PAD_NONE, 6'd0));
        send_word(mk_word(ito_pkg::KIND_HEXP, 32'h8000_0000, SIGN_NONE, PAD_NONE, 6'd0));
        send_word(mk_word(ito_pkg::KIND_HEXP, 32'd0,         SIGN_NONE, PAD_NONE, 6'd0));
        send_word(mk_word(KIND_ODD,           32'hdead_beef, SIGN_NONE, PAD_NONE, 6'd0));
        send_word(mk_word(KIND_ODD,           32'h1234_abcd, SIGN_NONE, PAD_NONE, 6'd0));
        send_word(mk_word(KIND_HEX,           32'hffff_ff01, SIGN_NONE, PAD_NONE, 6'd0));
    endtask

    task automatic test_sign_and_padding();
        send_word(mk_word(ito_pkg::KIND_DEC, 32'd42, ito_pkg::SIGN_PLUS, ito_pkg::PAD_SPACE,
                          6'd8));
        send_word(mk_word(ito_pkg::KIND_DEC, 32'd42, ito_pkg::SIGN_PLUS, ito_pkg::PAD_ZERO,
                          6'd8));
        send_word(mk_word(ito_pkg::KIND_DEC, 32'hffff_ffd6, ito_pkg::SIGN_MIN,
                          ito_pkg::PAD_SPACE, 6'd8));
        send_word(mk_word(ito_pkg::KIND_DEC, 32'd42, ito_pkg::SIGN_MIN, ito_pkg::PAD_ZERO,
                          6'd10));
        send_word(mk_word(ito_pkg::KIND_DEC, 32'd7, SIGN_ODD, ito_pkg::PAD_SPACE, 6'd5));
        send_word(mk_word(ito_pkg::KIND_DEC, 32'd7, SIGN_NONE, PAD_ODD, 6'd20));
        send_word(mk_word(ito_pkg::KIND_DEC, 32'd123, SIGN_NONE, ito_pkg::PAD_ZERO, 6'd63));
        send_word(mk_word(ito_pkg::KIND_DEC, 32'd123, SIGN_NONE, ito_pkg::PAD_ZERO, 6'd49));
        send_word(mk_word(ito_pkg::KIND_HEXP, 32'hffff_ffff, ito_pkg::SIGN_PLUS,
                          ito_pkg::PAD_ZERO, 6'd48));
        send_word(mk_word(ito_pkg::KIND_DEC, 32'd12345, SIGN_NONE, ito_pkg::PAD_SPACE,
                          6'd3));
        send_word(mk_word(ito_pkg::KIND_DEC, 32'd5, ito_pkg::SIGN_PLUS, ito_pkg::PAD_SPACE,
                          6'd2));
        send_word(mk_word(ito_pkg::KIND_DEC, 32'h8000_0000, SIGN_NONE, ito_pkg::PAD_ZERO,
                          6'd48));
    endtask

    // receiver stalls long while words keep coming, so the input side backs up
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        repeat (15) send_word(rand_word());
        wait (!hold_req);
    endtask

    task automatic test_random_with_gaps();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (340) send_word(rand_word());
    endtask

    task automatic test_random_streaming();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (110) send_word(rand_word());
    endtask

    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        ito_pkg::t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_chars.size() == 0) begin
                $error("unexpected word: out_char %h last %b", o_out_word.out_char,
                       o_out_word.last);
                errors++;
            end else begin
                e = exp_chars.pop_front();
                if (o_out_word.out_char !== e.out_char) begin
                    $error("out_char expected %h actual %h", e.out_char, o_out_word.out_char);
                    errors++;
                end
                if (o_out_word.last !== e.last) begin
                    $error("last expected %b actual %b", e.last, o_out_word.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        int guard;
        errors   = 0;
        tx_idle  = 1'b1;
        rx_idle  = 1'b1;
        hold_req = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_kinds_and_extremes();
        test_sign_and_padding();
        test_output_backpressure();
        test_random_with_gaps();
        test_random_streaming();
        i_in_valid <= 1'b0;

        guard = 0;
        while (exp_chars.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (exp_chars.size() != 0) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            repeat (100) @(posedge i_clk);
            if (errors == 0) begin
                $display("Test completed successfully");
            end else begin
                $display("Test completed with failures");
            end
            $finish;
        end
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
